FILE: rtl/stq_pkg.sv
// Shared constants for the sorted deadline timer queue.
// No dependencies; imported by the RAM and the top level.
package stq_pkg;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_BITS     = 8;
	localparam int TIME_W          = 64;
	localparam int DELAY_W         = 32;
	localparam int WID_W           = 8;
	localparam int KIND_W          = 2;
	localparam int IN_DATA_W       = 104;
	localparam int OUT_DATA_W      = 80;
	localparam logic [31:0] LONG_SLEEP_RST = 32'd1000000;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_EXPIRE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WOKEN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SLEEP  = 2'd2;
endpackage

FILE: rtl/stq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on stq_pkg for its parameter defaults.
module stq_ram import stq_pkg::*; #(
	parameter int WIDTH = DEF_ID_BITS + TIME_W,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: rtl/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue: circular store in one RAM, kept in wake order.
// Insert: each later entry is read, compared and moved up one slot; the new one lands
// in the freed slot, then the output slot; a refused insert (queue full) goes straight there.
// Expire: per woken waiter a read, a compare and a report, then a closing sleep report; output stalls hold each report.
// One transaction is worked at a time; a new one is taken while the last result waits.
// arst_n clears occupancy, head pointer and handshake state, and sets long sleep to 1000000.
module sorted_deadline_timer_queue import stq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // waiter_id, delay_usecs, current_time
	input  logic                  s_tuser,  // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // woken_id, accepted, sleep_usecs, zero pad
	output logic [KIND_W-1:0]     m_tuser,  // kind
	output logic                  m_tlast,
	input  logic                  cfg_wr_en,
	input  logic [31:0]           cfg_wr_data
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = CW + 1;
	localparam int EW = ID_BITS + TIME_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_INS_RD  = 3'd1;
	localparam logic [2:0] ST_INS_CMP = 3'd2;
	localparam logic [2:0] ST_EXP_RD  = 3'd3;
	localparam logic [2:0] ST_EXP_CMP = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      head_q;
	logic [31:0]        long_q;
	logic [TIME_W-1:0]  wake_q;
	logic [TIME_W-1:0]  now_q;
	logic [ID_BITS-1:0] id_q;

	logic [KIND_W-1:0]  pend_kind_q;
	logic [WID_W-1:0]   pend_id_q;
	logic               pend_acc_q;
	logic [TIME_W-1:0]  pend_sleep_q;
	logic               pend_last_q;

	logic [WID_W-1:0]   out_id_q;
	logic               out_acc_q;
	logic [TIME_W-1:0]  out_sleep_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic               out_last_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [EW-1:0]      wr_data;
	logic [AW-1:0]      rd_addr;
	logic [EW-1:0]      rd_data;
	logic [TIME_W-1:0]  rd_wake;
	logic [ID_BITS-1:0] rd_id;

	logic [WID_W-1:0]   in_id;
	logic [DELAY_W-1:0] in_delay;
	logic [TIME_W-1:0]  in_now;
	logic [TIME_W:0]    wake_sum;
	logic [ID_BITS+WID_W-1:0] id_in_ext;
	logic [ID_BITS+WID_W-1:0] id_out_ext;
	logic               accept;
	logic               out_free;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
		logic [PW-1:0] s;
		s = PW'(head) + PW'(l);
		if (s >= PW'(QUEUE_DEPTH)) begin
			s = s - PW'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign in_id     = s_tdata[WID_W-1:0];
	assign in_delay  = s_tdata[WID_W+DELAY_W-1:WID_W];
	assign in_now    = s_tdata[WID_W+DELAY_W+TIME_W-1:WID_W+DELAY_W];
	assign wake_sum  = {1'b0, in_now} + {{(TIME_W-DELAY_W+1){1'b0}}, in_delay};
	assign id_in_ext = {{ID_BITS{1'b0}}, in_id};

	assign rd_wake    = rd_data[TIME_W-1:0];
	assign rd_id      = rd_data[EW-1:TIME_W];
	assign id_out_ext = {{WID_W{1'b0}}, rd_id};

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign m_tdata = {{(OUT_DATA_W-WID_W-1-TIME_W){1'b0}}, out_sleep_q, out_acc_q, out_id_q};
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

	assign rd_addr = (state_q == ST_INS_RD) ? phys(head_q, idx_q - CW'(1)) : head_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(head_q, idx_q);
		wr_data = {id_q, wake_q};
		if (state_q == ST_INS_RD && idx_q == '0) begin
			wr_en = 1'b1;
		end else if (state_q == ST_INS_CMP) begin
			wr_en = 1'b1;
			if (rd_wake > wake_q) begin
				wr_data = rd_data;
			end
		end
	end

	stq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= LONG_SLEEP_RST;
		end else if (cfg_wr_en) begin
			long_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wake_q <= wake_sum[TIME_W] ? {TIME_W{1'b1}} : wake_sum[TIME_W-1:0];
			now_q  <= in_now;
			id_q   <= id_in_ext[ID_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			m_tvalid     <= 1'b0;
			pend_kind_q  <= KIND_INSERT;
			pend_id_q    <= '0;
			pend_acc_q   <= 1'b0;
			pend_sleep_q <= '0;
			pend_last_q  <= 1'b0;
			out_kind_q   <= KIND_INSERT;
			out_id_q     <= '0;
			out_acc_q    <= 1'b0;
			out_sleep_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// the output slot loads itself in ST_EMIT
			if (m_tvalid && m_tready && state_q != ST_EMIT) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == OP_EXPIRE) begin
							state_q <= ST_EXP_RD;
						end else if (cnt_q == CW'(QUEUE_DEPTH)) begin
							pend_kind_q  <= KIND_INSERT;
							pend_id_q    <= '0;
							pend_acc_q   <= 1'b0;
							pend_sleep_q <= '0;
							pend_last_q  <= 1'b1;
							state_q      <= ST_EMIT;
						end else begin
							idx_q   <= cnt_q;
							state_q <= ST_INS_RD;
						end
					end
				end
				ST_INS_RD: begin
					if (idx_q == '0) begin
						cnt_q        <= cnt_q + CW'(1);
						pend_kind_q  <= KIND_INSERT;
						pend_id_q    <= '0;
						pend_acc_q   <= 1'b1;
						pend_sleep_q <= '0;
						pend_last_q  <= 1'b1;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					// later entry moves up one slot; otherwise the new one lands here
					if (rd_wake > wake_q) begin
						idx_q   <= idx_q - CW'(1);
						state_q <= ST_INS_RD;
					end else begin
						cnt_q        <= cnt_q + CW'(1);
						pend_kind_q  <= KIND_INSERT;
						pend_id_q    <= '0;
						pend_acc_q   <= 1'b1;
						pend_sleep_q <= '0;
						pend_last_q  <= 1'b1;
						state_q      <= ST_EMIT;
					end
				end
				ST_EXP_RD: begin
					if (cnt_q == '0) begin
						pend_kind_q  <= KIND_SLEEP;
						pend_id_q    <= '0;
						pend_acc_q   <= 1'b0;
						pend_sleep_q <= {{(TIME_W-32){1'b0}}, long_q};
						pend_last_q  <= 1'b1;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= ST_EXP_CMP;
					end
				end
				ST_EXP_CMP: begin
					pend_acc_q <= 1'b0;
					state_q    <= ST_EMIT;
					if (rd_wake <= now_q) begin
						pend_kind_q  <= KIND_WOKEN;
						pend_id_q    <= id_out_ext[WID_W-1:0];
						pend_sleep_q <= '0;
						pend_last_q  <= 1'b0;
						cnt_q        <= cnt_q - CW'(1);
						head_q       <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
					end else begin
						pend_kind_q  <= KIND_SLEEP;
						pend_id_q    <= '0;
						pend_sleep_q <= rd_wake - now_q;
						pend_last_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid    <= 1'b1;
						out_kind_q  <= pend_kind_q;
						out_id_q    <= pend_id_q;
						out_acc_q   <= pend_acc_q;
						out_sleep_q <= pend_sleep_q;
						out_last_q  <= pend_last_q;
						state_q     <= pend_last_q ? ST_IDLE : ST_EXP_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
